// File: rtl/audtgc_pkg.sv
// ---------------------------------------------------------------------------
// audtgc_pkg
// Shared types and constants for the audio timestamp gap corrector.
// ---------------------------------------------------------------------------
package audtgc_pkg;

	localparam int OP_W    = 2;
	localparam int ACT_W   = 3;
	localparam int TIME_W  = 64;
	localparam int BYTES_W = 24;
	localparam int FRM_W   = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int S_DATA_W = 160;
	localparam int M_DATA_W = 240;

	localparam logic [OP_W-1:0] OP_PACKET = 2'd0;
	localparam logic [OP_W-1:0] OP_SEG    = 2'd1;
	localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_PASS = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DROP = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CROP = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PAD  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CTRL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_RATE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BITSTREAM   = 3'd4;

	localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX24 = 64'h0000_0000_00FF_FFFF;

	typedef enum logic [11:0] {
		ST_X   = 12'b000000000001,
		ST_E   = 12'b000000000010,
		ST_SS  = 12'b000000000100,
		ST_N1  = 12'b000000001000,
		ST_N2  = 12'b000000010000,
		ST_N3  = 12'b000000100000,
		ST_N4  = 12'b000001000000,
		ST_PAY = 12'b000010000000,
		ST_G   = 12'b000100000000,
		ST_F   = 12'b001000000000,
		ST_T1  = 12'b010000000000,
		ST_T2  = 12'b100000000000
	} step_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL0 = 7'b0000010,
		S_MUL1 = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_STEP = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	function automatic logic [63:0] sat63(input logic [63:0] x);
		return (x > MAX63) ? MAX63 : x;
	endfunction

	function automatic logic less_s(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

// File: rtl/audio_timestamp_gap_corrector_unit.sv
// ---------------------------------------------------------------------------
// audio_timestamp_gap_corrector_unit
// Audio packet timestamp repair: fill, drop, crop and zero-pad decisions.
// ---------------------------------------------------------------------------
// One item at a time. All scaling runs on one shared multiply-divide unit
// computing floor(a*b/c): a 64x32 product built from 32x32 partial products
// in S_MUL0 and S_MUL1, then a restoring divider giving one quotient bit per
// cycle for a 64-bit quotient, and S_STEP takes the result. A control item
// goes straight to the output (segment start) or takes one operation (format
// close); a packet takes 3 to 12 operations and then S_FIN before the result
// is offered. s_axis_tready is high only while idle.
module audio_timestamp_gap_corrector_unit
	import audtgc_pkg::*;
#(
	parameter int TIME_UNITS_PER_SECOND = 10000000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// start_time[63:0], start_valid[64], stop_time[128:65], stop_valid[129],
	// byte_count[153:130], zero fill
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  logic [OP_W-1:0]       s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_start[63:0], out_stop[127:64], out_bytes[151:128],
	// adjust_bytes[175:152], timing_error[239:176]
	output logic [M_DATA_W-1:0]   m_axis_tdata,
	// action[2:0]
	output logic [ACT_W-1:0]      m_axis_tuser
);

	localparam logic [31:0] UNITS = 32'(TIME_UNITS_PER_SECOND);

	logic [18:0] sr_q;
	logic [3:0]  ch_q;
	logic [5:0]  bits_q;
	logic [23:0] pr_q;
	logic        bs_q;

	logic [47:0] fd_q;
	logic [63:0] earlier_q, seg_q, prev_q;

	state_t state_q;
	step_t  step_q;

	logic [OP_W-1:0] op_q;
	logic [63:0] start_q, stop_q;
	logic        sv_q, tv_q;
	logic [23:0] bytes_q;
	logic [63:0] x_q, e_q, t_q, d_q;
	logic [23:0] pay_q;
	logic [47:0] f_q;
	logic        crop_q;
	logic [ACT_W-1:0] act_q;

	logic [95:0] prod_q;
	logic [31:0] rem_q;
	logic [63:0] lo_q, quo_q;
	logic [5:0]  cnt_q;
	logic        ovf_q;

	logic [M_DATA_W-1:0] odata_q;
	logic [ACT_W-1:0]    ouser_q;

	logic [31:0] e_sr, e_ch, e_bits, e_pr, fb;
	logic [9:0]  chbits;
	assign e_sr   = (sr_q == '0) ? 32'd1 : {13'd0, sr_q};
	assign e_ch   = (ch_q == '0) ? 32'd1 : {28'd0, ch_q};
	assign e_bits = (bits_q == '0) ? 32'd1 : {26'd0, bits_q};
	assign e_pr   = (pr_q == '0) ? 32'd1 : {8'd0, pr_q};
	assign chbits = e_ch[3:0] * e_bits[5:0];
	assign fb     = (chbits[9:3] == '0) ? 32'd1 : {25'd0, chbits[9:3]};

	logic [63:0] op_a;
	logic [31:0] op_b, op_c;
	logic [63:0] fold_sum;
	assign fold_sum = sat63(earlier_q + x_q);

	always_comb begin
		op_a = {16'd0, fd_q};
		op_b = UNITS;
		op_c = e_sr;
		unique case (step_q)
			ST_X:   begin op_a = {16'd0, fd_q}; op_b = UNITS;     op_c = e_sr;   end
			ST_E:   begin op_a = x_q;           op_b = 32'd65536; op_c = e_pr;   end
			ST_SS:  begin op_a = fold_sum;      op_b = 32'd65536; op_c = e_pr;   end
			ST_N1:  begin op_a = {40'd0, bytes_q}; op_b = 32'd8;  op_c = e_bits; end
			ST_N2:  begin op_a = t_q;           op_b = 32'd1;     op_c = e_ch;   end
			ST_N3:  begin op_a = t_q;           op_b = UNITS;     op_c = e_sr;   end
			ST_N4:  begin op_a = t_q;           op_b = 32'd65536; op_c = e_pr;   end
			ST_PAY: begin op_a = {40'd0, bytes_q}; op_b = 32'd1;  op_c = fb;     end
			ST_G:   begin op_a = d_q;           op_b = e_sr;      op_c = UNITS;  end
			ST_F:   begin op_a = t_q;           op_b = e_pr;      op_c = 32'd65536; end
			ST_T1:  begin op_a = {16'd0, f_q};  op_b = UNITS;     op_c = e_sr;   end
			ST_T2:  begin op_a = t_q;           op_b = 32'd65536; op_c = e_pr;   end
			default: ;
		endcase
	end

	logic [95:0] prod_full;
	logic [32:0] r2;
	logic        ge;
	logic [63:0] res;
	assign prod_full = prod_q + {{32'd0, op_a[63:32]} * {32'd0, op_b}, 32'd0};
	assign r2  = {rem_q, lo_q[63]};
	assign ge  = r2 >= {1'b0, op_c};
	assign res = ovf_q ? '1 : quo_q;

	logic [63:0] res63, fclamp;
	assign res63 = sat63(res);
	always_comb begin
		if (crop_q)
			fclamp = (res > {40'd0, pay_q}) ? {40'd0, pay_q} : res;
		else
			fclamp = (res > MAX48) ? MAX48 : res;
	end

	logic [63:0] ffb, fin_frames, fin_adj, fin_obytes, pad_total;
	logic [49:0] fd_sum;
	assign ffb       = {16'd0, f_q} * {32'd0, fb};
	assign pad_total = {40'd0, bytes_q} + ffb;
	always_comb begin
		fin_frames = {40'd0, pay_q};
		fin_adj    = '0;
		fin_obytes = {40'd0, bytes_q};
		case (act_q)
			ACT_DROP: begin
				fin_frames = '0;
				fin_obytes = '0;
			end
			ACT_CROP: begin
				fin_frames = {40'd0, pay_q} - {16'd0, f_q};
				fin_adj    = ffb;
				fin_obytes = {40'd0, bytes_q} - ffb;
			end
			ACT_PAD: begin
				fin_frames = {40'd0, pay_q} + {16'd0, f_q};
				fin_adj    = (ffb > MAX24) ? MAX24 : ffb;
				fin_obytes = (pad_total > MAX24) ? MAX24 : pad_total;
			end
			default: ;
		endcase
	end
	assign fd_sum = {2'd0, fd_q} + fin_frames[49:0];

	logic [63:0] terr;
	assign terr = start_q - (earlier_q + e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q   <= 19'd48000;
			ch_q   <= 4'd2;
			bits_q <= 6'd16;
			pr_q   <= 24'd65536;
			bs_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: sr_q   <= cfg_data[18:0];
				REG_CHANNELS:    ch_q   <= cfg_data[3:0];
				REG_SAMPLE_BITS: bits_q <= cfg_data[5:0];
				REG_PLAY_RATE:   pr_q   <= cfg_data[23:0];
				REG_BITSTREAM:   bs_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= ST_X;
			fd_q      <= '0;
			earlier_q <= '0;
			seg_q     <= '0;
			prev_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tuser;
						start_q <= s_axis_tdata[63:0];
						sv_q    <= s_axis_tdata[64];
						stop_q  <= s_axis_tdata[128:65];
						tv_q    <= s_axis_tdata[129];
						bytes_q <= s_axis_tdata[153:130];
						crop_q  <= 1'b0;
						f_q     <= '0;
						step_q  <= ST_X;
						odata_q <= '0;
						ouser_q <= ACT_CTRL;
						if (s_axis_tuser == OP_PACKET || s_axis_tuser == OP_CLOSE) begin
							state_q <= S_MUL0;
						end else begin
							if (s_axis_tuser == OP_SEG) begin
								fd_q      <= '0;
								earlier_q <= '0;
								seg_q     <= '0;
								prev_q    <= '0;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_MUL0: begin
					prod_q  <= {32'd0, {32'd0, op_a[31:0]} * {32'd0, op_b}};
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					prod_q  <= prod_full;
					rem_q   <= prod_full[95:64];
					lo_q    <= prod_full[63:0];
					ovf_q   <= prod_full[95:64] >= op_c;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? 32'(r2 - {1'b0, op_c}) : r2[31:0];
					lo_q  <= {lo_q[62:0], 1'b0};
					quo_q <= {quo_q[62:0], ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= S_MUL0;
					unique case (step_q)
						ST_X: begin
							x_q <= res;
							if (op_q == OP_CLOSE) begin
								earlier_q <= sat63(earlier_q + res);
								fd_q      <= '0;
								state_q   <= S_OUT;
							end else begin
								step_q <= ST_E;
							end
						end
						ST_E: begin
							e_q <= res63;
							if (!sv_q)
								step_q <= ST_SS;
							else if (!tv_q)
								step_q <= ST_N1;
							else
								step_q <= ST_PAY;
						end
						ST_SS: begin
							start_q <= seg_q + res63;
							step_q  <= tv_q ? ST_PAY : ST_N1;
						end
						ST_N1: begin t_q <= res; step_q <= ST_N2; end
						ST_N2: begin t_q <= res; step_q <= ST_N3; end
						ST_N3: begin t_q <= res; step_q <= ST_N4; end
						ST_N4: begin
							stop_q <= start_q + res63;
							step_q <= ST_PAY;
						end
						ST_PAY: begin
							pay_q <= res[23:0];
							act_q <= ACT_PASS;
							if (bs_q || prev_q == '0) begin
								state_q <= S_FIN;
							end else if (!less_s(prev_q, stop_q)) begin
								act_q   <= ACT_DROP;
								state_q <= S_FIN;
							end else if (less_s(start_q, prev_q)) begin
								d_q    <= prev_q - start_q;
								crop_q <= 1'b1;
								step_q <= ST_G;
							end else if (less_s(prev_q, start_q)) begin
								d_q    <= start_q - prev_q;
								crop_q <= 1'b0;
								step_q <= ST_G;
							end else begin
								state_q <= S_FIN;
							end
						end
						ST_G: begin t_q <= res; step_q <= ST_F; end
						ST_F: begin
							f_q <= fclamp[47:0];
							if (fclamp == '0) begin
								state_q <= S_FIN;
							end else begin
								act_q  <= crop_q ? ACT_CROP : ACT_PAD;
								step_q <= ST_T1;
							end
						end
						ST_T1: begin t_q <= res; step_q <= ST_T2; end
						ST_T2: begin
							start_q <= crop_q ? start_q + res63 : start_q - res63;
							state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					if (fd_q == '0)
						seg_q <= start_q;
					fd_q    <= (fd_sum > {2'd0, MAX48[47:0]}) ? MAX48[47:0] : fd_sum[47:0];
					prev_q  <= stop_q;
					ouser_q <= act_q;
					odata_q <= {terr, fin_adj[23:0], fin_obytes[23:0], stop_q, start_q};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output sides open together");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == 6'd63) |=> state_q == S_STEP)
		else $error("divider did not hand over after 64 bits");
	a_fd_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> fd_q >= $past(fd_q) || $past(op_q) != OP_PACKET)
		else $error("frame counter went backwards");

endmodule

// File: test/audtgc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audtgc_checker
// Watches the configuration port and both streams of the gap corrector. It
// keeps its own copy of the registers and the segment state, works out each
// expected result when an input transfer happens, and compares each output
// transfer field by field with the oldest expected result.
// ---------------------------------------------------------------------------
module audtgc_checker
	import audtgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	input  logic [OP_W-1:0]       s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_DATA_W-1:0]   m_axis_tdata,
	input  logic [ACT_W-1:0]      m_axis_tuser,
	output int                    fail_count,
	output int                    pending
);

	localparam logic [63:0] UNITS = 64'd10000000;

	typedef struct {
		logic [ACT_W-1:0]   act;
		logic [63:0]        start;
		logic [63:0]        stop;
		logic [BYTES_W-1:0] bytes;
		logic [BYTES_W-1:0] adj;
		logic [63:0]        terr;
	} fix_t;

	fix_t fix_q[$];

	logic [63:0] rate, chans, bits, prate, bitstream;
	logic [63:0] frames, fmt_time, seg_start, prev_end;

	function automatic logic [63:0] nz(logic [63:0] v);
		return (v == 0) ? 64'd1 : v;
	endfunction

	function automatic logic [63:0] clamp63(logic [63:0] v);
		return (v > MAX63) ? MAX63 : v;
	endfunction

	function automatic logic [63:0] scale(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [127:0] q;
		q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic logic [63:0] to_units(logic [63:0] f);
		return scale(f, UNITS, nz(rate));
	endfunction

	function automatic logic [63:0] by_prate(logic [63:0] x);
		return clamp63(scale(x, 64'd65536, nz(prate)));
	endfunction

	function automatic logic [63:0] to_frames(logic [63:0] d);
		return scale(scale(d, nz(rate), UNITS), nz(prate), 64'd65536);
	endfunction

	function automatic fix_t correct_packet(logic [OP_W-1:0] op, logic [63:0] st_in,
			logic st_ok, logic [63:0] sp_in, logic sp_ok, logic [63:0] nbytes);
		fix_t r;
		logic [63:0] st, sp, fb, pay, frm, adj, ob, f, old;
		logic [ACT_W-1:0] act;
		r = '{ACT_CTRL, 0, 0, 0, 0, 0};
		if (op == OP_SEG) begin
			frames = 0;
			fmt_time = 0;
			seg_start = 0;
			prev_end = 0;
			return r;
		end
		if (op == OP_CLOSE) begin
			fmt_time = clamp63(fmt_time + to_units(frames));
			frames = 0;
			return r;
		end
		if (op != OP_PACKET)
			return r;
		st = st_in;
		sp = sp_in;
		if (!st_ok)
			st = seg_start + by_prate(clamp63(fmt_time + to_units(frames)));
		if (!sp_ok)
			sp = st + by_prate(to_units(nbytes * 8 / nz(bits) / nz(chans)));
		fb = nz(nz(chans) * nz(bits) / 8);
		pay = nbytes / fb;
		frm = pay;
		adj = 0;
		ob = nbytes;
		act = ACT_PASS;
		if (bitstream[0] || prev_end == 0) begin
			act = ACT_PASS;
		end else if (!($signed(prev_end) < $signed(sp))) begin
			act = ACT_DROP;
			frm = 0;
			ob = 0;
		end else if ($signed(st) < $signed(prev_end)) begin
			f = to_frames(prev_end - st);
			if (f > pay)
				f = pay;
			if (f > 0) begin
				act = ACT_CROP;
				adj = f * fb;
				ob = nbytes - adj;
				st = st + by_prate(to_units(f));
				frm = pay - f;
			end
		end else if ($signed(prev_end) < $signed(st)) begin
			f = to_frames(st - prev_end);
			if (f > MAX48)
				f = MAX48;
			if (f > 0) begin
				act = ACT_PAD;
				adj = (f * fb > MAX24) ? MAX24 : f * fb;
				ob = (nbytes + f * fb > MAX24) ? MAX24 : nbytes + f * fb;
				st = st - by_prate(to_units(f));
				frm = pay + f;
			end
		end
		if (frames == 0)
			seg_start = st;
		old = frames;
		frames = (frm > MAX48 - frames) ? MAX48 : frames + frm;
		prev_end = sp;
		r.act = act;
		r.start = st;
		r.stop = sp;
		r.bytes = ob[23:0];
		r.adj = adj[23:0];
		r.terr = st - (fmt_time + by_prate(to_units(old)));
		return r;
	endfunction

	task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s expected %h got %h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fix_t e;
		if (!arst_n) begin
			rate = 48000;
			chans = 2;
			bits = 16;
			prate = 65536;
			bitstream = 0;
			frames = 0;
			fmt_time = 0;
			seg_start = 0;
			prev_end = 0;
			fix_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_RATE: rate = 64'(cfg_data[18:0]);
					REG_CHANNELS:    chans = 64'(cfg_data[3:0]);
					REG_SAMPLE_BITS: bits = 64'(cfg_data[5:0]);
					REG_PLAY_RATE:   prate = 64'(cfg_data[23:0]);
					REG_BITSTREAM:   bitstream = 64'(cfg_data[0]);
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (fix_q.size() == 0) begin
					$error("unexpected output transfer, action %0d", m_axis_tuser);
					fail_count++;
				end else begin
					e = fix_q.pop_front();
					cmp("action", 64'(e.act), 64'(m_axis_tuser));
					cmp("out_start", e.start, m_axis_tdata[63:0]);
					cmp("out_stop", e.stop, m_axis_tdata[127:64]);
					cmp("out_bytes", 64'(e.bytes), 64'(m_axis_tdata[151:128]));
					cmp("adjust_bytes", 64'(e.adj), 64'(m_axis_tdata[175:152]));
					cmp("timing_error", e.terr, m_axis_tdata[239:176]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				fix_q.push_back(correct_packet(s_axis_tuser, s_axis_tdata[63:0],
					s_axis_tdata[64], s_axis_tdata[128:65], s_axis_tdata[129],
					64'(s_axis_tdata[153:130])));
			pending = fix_q.size();
		end
	end

endmodule

// File: test/tb_audio_timestamp_gap_corrector_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_audio_timestamp_gap_corrector_unit
// Drives packet descriptors and control items through the gap corrector over
// several register settings: a directed set of corner cases, then mostly
// coherent packet timelines with random jitter, gaps, overlaps and late
// packets, mixed with raw noise. Both stream sides idle at random and the
// output is held off once for a long stretch. The checker does the scoring.
// ---------------------------------------------------------------------------
module tb_audio_timestamp_gap_corrector_unit;
	import audtgc_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int HOLD_OFF = 3000;
	localparam int PER_PHASE = 90;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;
	logic [OP_W-1:0]       s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [ACT_W-1:0]      m_axis_tuser;
	int                    fail_count;
	int                    pending;

	int tx_idle_pct = 17;
	int rx_idle_pct = 64;
	int hold_req = 0;
	int hold_done = 0;
	int quiet = 0;

	longint unsigned cur_rate = 48000, cur_fb = 4, cur_prate = 65536;
	longint t_next;

	audio_timestamp_gap_corrector_unit i_dut (.*);

	audtgc_checker i_chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			m_axis_tready <= 1'b0;
			repeat (HOLD_OFF) @(negedge clk);
			hold_done = hold_req;
		end
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("audio_timestamp_gap_corrector_unit: mismatch");
			$finish;
		end
	end

	task automatic send(logic [OP_W-1:0] op, longint st, bit sv, longint sp, bit pv,
			logic [23:0] nbytes);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, nbytes, pv, sp, sv, st};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic configure(int r, int ch, int b, int pr, int bs);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		write_reg(REG_SAMPLE_RATE, 24'(r));
		write_reg(REG_CHANNELS, 24'(ch));
		write_reg(REG_SAMPLE_BITS, 24'(b));
		write_reg(REG_PLAY_RATE, 24'(pr));
		write_reg(REG_BITSTREAM, 24'(bs));
		cfg_we <= 1'b0;
		cur_rate = longint'((r == 0) ? 1 : r);
		cur_fb = longint'(((ch == 0 ? 1 : ch) * (b == 0 ? 1 : b)) / 8);
		if (cur_fb == 0)
			cur_fb = 1;
		cur_prate = longint'((pr == 0) ? 1 : pr);
	endtask

	// one coherent packet following the running timeline
	task automatic timeline_packet();
		longint unsigned nfr, dur;
		longint jit, st;
		int pick;
		nfr = $urandom_range(1, 400);
		dur = nfr * 10000000 / cur_rate * 65536 / cur_prate;
		pick = $urandom_range(99);
		if (pick < 55)
			jit = 0;
		else if (pick < 72)
			jit = $urandom_range(1, 4000) * (dur / 100 + 1);
		else if (pick < 90)
			jit = -longint'($urandom_range(1, 150)) * longint'(dur / 100 + 1);
		else
			jit = -longint'(3 * dur + $urandom_range(1, 1000));
		st = t_next + jit;
		t_next = st + longint'(dur);
		send(OP_PACKET, st, $urandom_range(99) < 88, t_next, $urandom_range(99) < 88,
			24'(nfr * cur_fb + (($urandom_range(9) == 0) ? $urandom_range(3) : 0)));
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 7) begin
			send(OP_SEG, 0, 0, 0, 0, 0);
			t_next = $urandom_range(1, 1 << 30);
		end else if (pick < 12) begin
			send(OP_CLOSE, 0, 0, 0, 0, 0);
		end else if (pick < 22) begin
			send(2'($urandom_range(3)), {$urandom, $urandom}, 1'($urandom),
				{$urandom, $urandom}, 1'($urandom), 24'($urandom));
		end else begin
			timeline_packet();
		end
	endtask

	initial begin
		int r[8] = '{48000, 48000, 44100, 384000, 1, 96000, 0, 48000};
		int ch[8] = '{2, 2, 6, 8, 1, 2, 0, 2};
		int b[8] = '{16, 16, 24, 32, 8, 16, 0, 16};
		int pr[8] = '{65536, 65536, 98304, 16777215, 1, 32768, 0, 65536};
		int bs[8] = '{0, 0, 0, 0, 0, 1, 0, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_PACKET;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: 4 bytes per frame, 48 kHz, unit rate
		send(OP_PACKET, 1000, 1, 21833, 1, 400);            // first packet passes
		send(OP_PACKET, 0, 0, 0, 0, 400);                   // both times filled
		send(OP_PACKET, 70000, 1, 90833, 1, 400);           // gap: zero pad
		send(OP_PACKET, 85000, 1, 105833, 1, 400);          // overlap: crop
		send(OP_PACKET, 50000, 1, 100000, 1, 400);          // ends too early: drop
		send(OP_PACKET, 105834, 1, 126667, 1, 400);         // gap after the dropped packet's stop: zero pad
		send(OP_PACKET, 1000, 1, 126668, 1, 8);             // crop larger than payload
		send(OP_PACKET, 126668, 1, 126000, 0, 0);           // empty payload
		send(OP_PACKET, 200000, 1, 0, 0, 24'hFFFFFF);       // largest byte count
		send(OP_PACKET, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h8000_0000_0000_0000, 1, 4);
		send(OP_PACKET, 64'h8000_0000_0000_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1, 4);
		send(OP_PACKET, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0005, 1, 24'hFFFFFF);
		send(2'd3, -1, 1, -1, 1, 24'hFFFFFF);               // unused operation
		send(OP_CLOSE, 0, 0, 0, 0, 0);
		send(OP_PACKET, 0, 0, 0, 0, 4000);
		send(OP_CLOSE, 0, 0, 0, 0, 0);
		send(OP_PACKET, 0, 0, 0, 0, 4000);
		send(OP_SEG, 0, 0, 0, 0, 0);
		send(OP_PACKET, 0, 0, 0, 0, 400);                   // first after segment start
		send(OP_PACKET, 5000, 1, 3000, 1, 400);
		send(OP_SEG, -1, 1, -1, 1, 24'hFFFFFF);

		for (int ph = 1; ph < 8; ph++) begin
			configure(r[ph], ch[ph], b[ph], pr[ph], bs[ph]);
			if (ph <= 2) begin
				tx_idle_pct = 17;
				rx_idle_pct = 64;
			end else if (ph <= 4) begin
				tx_idle_pct = 64;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send(OP_SEG, 0, 0, 0, 0, 0);
			t_next = $urandom_range(1, 1 << 30);
			for (int n = 0; n < PER_PHASE; n++) begin
				if (ph == 2 && n == 10)
					hold_req++;
				random_item();
			end
		end
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (1000) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("audio_timestamp_gap_corrector_unit: match");
		end else begin
			$display("audio_timestamp_gap_corrector_unit: mismatch");
		end
		$finish;
	end

endmodule
